>>> src/r2q_pkg.sv
// ----------------------------------------------------------------------------
// r2q_pkg
// Shared types, widths and helpers for the rotation-matrix-to-quaternion block.
// ----------------------------------------------------------------------------
`default_nettype none

package r2q_pkg;

  localparam int FIELD_W       = 18;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_W         = FIELD_W + 1;  // sum or difference of two elements
  localparam int FIFO_DEPTH    = 4;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_e;

  // width of the unsigned radicand T
  function automatic int t_w(input int fb);
    t_w = ((fb > 19) ? fb : 19) + 2;
  endfunction

  // width of the root of T << fb
  function automatic int sqrt_w(input int fb);
    sqrt_w = (t_w(fb) + fb + 1) / 2;
  endfunction

endpackage

`default_nettype wire

>>> src/r2q_front.sv
// ----------------------------------------------------------------------------
// r2q_front
// Picks the branch, forms the radicand and the three off-diagonal numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module r2q_front #(
  parameter int FRAC_BITS = r2q_pkg::FRAC_BITS_DEF
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire                                       in_valid_i,
  output logic                                      in_ready_o,
  input  wire  signed [r2q_pkg::FIELD_W-1:0]        r00_i,
  input  wire  signed [r2q_pkg::FIELD_W-1:0]        r01_i,
  input  wire  signed [r2q_pkg::FIELD_W-1:0]        r02_i,
  input  wire  signed [r2q_pkg::FIELD_W-1:0]        r10_i,
  input  wire  signed [r2q_pkg::FIELD_W-1:0]        r11_i,
  input  wire  signed [r2q_pkg::FIELD_W-1:0]        r12_i,
  input  wire  signed [r2q_pkg::FIELD_W-1:0]        r20_i,
  input  wire  signed [r2q_pkg::FIELD_W-1:0]        r21_i,
  input  wire  signed [r2q_pkg::FIELD_W-1:0]        r22_i,
  output logic                                      f_valid_o,
  input  wire                                       f_ready_i,
  output r2q_pkg::branch_e                          f_br_o,
  output logic        [r2q_pkg::t_w(FRAC_BITS)-1:0] f_t_o,
  output logic signed [r2q_pkg::NUM_W-1:0]          f_na_o,
  output logic signed [r2q_pkg::NUM_W-1:0]          f_nb_o,
  output logic signed [r2q_pkg::NUM_W-1:0]          f_nc_o
);

  localparam int TW = r2q_pkg::t_w(FRAC_BITS);
  localparam int EW = TW + 1;
  localparam int NW = r2q_pkg::NUM_W;
  localparam logic signed [EW-1:0] ONE_S = EW'(1) << FRAC_BITS;

  logic signed [EW-1:0] e00, e11, e22, trace, t_sel;
  logic signed [NW-1:0] d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
  r2q_pkg::branch_e     br;
  logic signed [NW-1:0] na, nb, nc;

  logic                          vld_q, vld_d;
  r2q_pkg::branch_e              br_q;
  logic [TW-1:0]                 t_q;
  logic signed [NW-1:0]          na_q, nb_q, nc_q;
  logic                          load;

  assign e00   = EW'(r00_i);
  assign e11   = EW'(r11_i);
  assign e22   = EW'(r22_i);
  assign trace = e00 + e11 + e22;

  assign d21_12 = NW'(r21_i) - NW'(r12_i);
  assign d02_20 = NW'(r02_i) - NW'(r20_i);
  assign d10_01 = NW'(r10_i) - NW'(r01_i);
  assign s01_10 = NW'(r01_i) + NW'(r10_i);
  assign s02_20 = NW'(r02_i) + NW'(r20_i);
  assign s12_21 = NW'(r12_i) + NW'(r21_i);

  // ties on the diagonal fall through to the later branch
  always_comb begin
    if (trace > 0) begin
      br    = r2q_pkg::BR_TRACE;
      t_sel = ONE_S + trace;
      na = d21_12; nb = d02_20; nc = d10_01;
    end else if (e00 > e11 && e00 > e22) begin
      br    = r2q_pkg::BR_X;
      t_sel = ONE_S + e00 - e11 - e22;
      na = s01_10; nb = s02_20; nc = d21_12;
    end else if (e11 > e22) begin
      br    = r2q_pkg::BR_Y;
      t_sel = ONE_S + e11 - e00 - e22;
      na = s01_10; nb = s12_21; nc = d02_20;
    end else begin
      br    = r2q_pkg::BR_Z;
      t_sel = ONE_S + e22 - e00 - e11;
      na = s02_20; nb = s12_21; nc = d10_01;
    end
    if (t_sel < ONE_S) begin
      t_sel = ONE_S;
    end
  end

  assign in_ready_o = !vld_q || f_ready_i;
  assign load       = in_valid_i && in_ready_o;
  assign vld_d      = load ? 1'b1 : (f_ready_i ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      br_q <= br;
      t_q  <= t_sel[TW-1:0];
      na_q <= na;
      nb_q <= nb;
      nc_q <= nc;
    end
  end

  assign f_valid_o = vld_q;
  assign f_br_o    = br_q;
  assign f_t_o     = t_q;
  assign f_na_o    = na_q;
  assign f_nb_o    = nb_q;
  assign f_nc_o    = nc_q;

endmodule

`default_nettype wire

>>> src/r2q_fifo.sv
// ----------------------------------------------------------------------------
// r2q_fifo
// Small register queue between the classifier and the arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module r2q_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = r2q_pkg::FIFO_DEPTH
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          push_valid_i,
  output logic         push_ready_o,
  input  wire  [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  wire          pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> src/r2q_div.sv
// ----------------------------------------------------------------------------
// r2q_div
// Pipelined restoring divider: round(|n| * ONE / (2R)), one quotient bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module r2q_div #(
  parameter int FRAC_BITS = r2q_pkg::FRAC_BITS_DEF
) (
  input  wire                                          clk_i,
  input  wire                                          en_i,
  input  wire  signed [r2q_pkg::NUM_W-1:0]             num_i,
  input  wire         [r2q_pkg::sqrt_w(FRAC_BITS)-1:0] root_i,
  output logic        [r2q_pkg::FIELD_W-1:0]           q_o,
  output logic                                         neg_o
);

  localparam int SW = r2q_pkg::sqrt_w(FRAC_BITS);
  // magnitude of a sum of two full-scale elements needs the full numerator width
  localparam int MW = r2q_pkg::NUM_W;
  localparam int QW = r2q_pkg::FIELD_W;
  localparam int DW = MW + FRAC_BITS + 1;
  localparam int CW = ((DW > SW + QW) ? DW : SW + QW) + 1;
  localparam int NW = r2q_pkg::NUM_W;

  logic [CW-1:0] rem_a [QW+1];
  logic [CW-1:0] den_a [QW+1];
  logic [QW-1:0] q_a   [QW+1];
  logic          neg_a [QW+1];

  logic [NW-1:0] mag_full;
  logic [MW-1:0] mag;

  assign mag_full = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
  assign mag      = mag_full[MW-1:0];

  // dividend carries the half-divisor so the quotient rounds half up
  assign rem_a[0] = (CW'(mag) << FRAC_BITS) + CW'(root_i);
  assign den_a[0] = CW'({root_i, 1'b0});
  assign q_a[0]   = '0;
  assign neg_a[0] = num_i[NW-1];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [CW-1:0] sh;
    logic          take;
    logic [CW-1:0] rem_d;
    logic [QW-1:0] q_d;

    assign sh    = den_a[j] << (QW - 1 - j);
    assign take  = (rem_a[j] >= sh);
    assign rem_d = take ? rem_a[j] - sh : rem_a[j];
    assign q_d   = {q_a[j][QW-2:0], take};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_a[j+1] <= rem_d;
        den_a[j+1] <= den_a[j];
        q_a[j+1]   <= q_d;
        neg_a[j+1] <= neg_a[j];
      end
    end
  end

  assign q_o   = q_a[QW];
  assign neg_o = neg_a[QW];

endmodule

`default_nettype wire

>>> src/r2q_back.sv
// ----------------------------------------------------------------------------
// r2q_back
// Pipelined square root, three dividers, saturation and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module r2q_back #(
  parameter int FRAC_BITS = r2q_pkg::FRAC_BITS_DEF
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire                                       b_valid_i,
  output logic                                      b_ready_o,
  input  r2q_pkg::branch_e                          b_br_i,
  input  wire         [r2q_pkg::t_w(FRAC_BITS)-1:0] b_t_i,
  input  wire  signed [r2q_pkg::NUM_W-1:0]          b_na_i,
  input  wire  signed [r2q_pkg::NUM_W-1:0]          b_nb_i,
  input  wire  signed [r2q_pkg::NUM_W-1:0]          b_nc_i,
  output logic                                      out_valid_o,
  input  wire                                       out_ready_i,
  output logic signed [r2q_pkg::FIELD_W-1:0]        quat_x_o,
  output logic signed [r2q_pkg::FIELD_W-1:0]        quat_y_o,
  output logic signed [r2q_pkg::FIELD_W-1:0]        quat_z_o,
  output logic signed [r2q_pkg::FIELD_W-1:0]        quat_w_o,
  output logic        [1:0]                         branch_case_o
);

  localparam int FW = r2q_pkg::FIELD_W;
  localparam int NW = r2q_pkg::NUM_W;
  localparam int TW = r2q_pkg::t_w(FRAC_BITS);
  localparam int SW = r2q_pkg::sqrt_w(FRAC_BITS);
  localparam int QW = FW;
  localparam int XW = ((SW > QW) ? SW : QW) + 2;
  localparam longint ONE_L = longint'(1) << FRAC_BITS;
  localparam longint LIM_P = (ONE_L > 131071) ? 131071 : ONE_L;
  localparam longint LIM_N = (ONE_L > 131072) ? 131072 : ONE_L;
  localparam logic [XW-1:0] ONE_X  = XW'(ONE_L);
  localparam logic [XW-1:0] LIMP_X = XW'(LIM_P);
  localparam logic [XW-1:0] LIMN_X = XW'(LIM_N);

  // clamp a magnitude to [-1, 1] and to the field range
  function automatic logic [FW-1:0] sat(input logic [XW-1:0] m, input logic neg);
    logic [XW-1:0] c;
    c = (m > ONE_X) ? ONE_X : m;
    if (neg) begin
      c = (c > LIMN_X) ? LIMN_X : c;
      c = XW'(0) - c;
    end else begin
      c = (c > LIMP_X) ? LIMP_X : c;
    end
    sat = c[FW-1:0];
  endfunction

  logic adv;
  logic o_vld_q;

  assign adv       = !o_vld_q || out_ready_i;
  assign b_ready_o = adv;

  // ---- square root, one root bit a stage ----
  logic [SW+1:0]        sq_rem  [SW+1];
  logic [SW-1:0]        sq_root [SW+1];
  logic [2*SW-1:0]      sq_v    [SW+1];
  logic                 sq_vld  [SW+1];
  r2q_pkg::branch_e     sq_br   [SW+1];
  logic signed [NW-1:0] sq_na   [SW+1];
  logic signed [NW-1:0] sq_nb   [SW+1];
  logic signed [NW-1:0] sq_nc   [SW+1];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_v[0]    = (2*SW)'({b_t_i, {FRAC_BITS{1'b0}}});
  assign sq_vld[0]  = b_valid_i;
  assign sq_br[0]   = b_br_i;
  assign sq_na[0]   = b_na_i;
  assign sq_nb[0]   = b_nb_i;
  assign sq_nc[0]   = b_nc_i;

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    logic [SW+1:0] rem_n, trial, rem_d;
    logic          take;
    logic [SW-1:0] root_d;

    assign rem_n  = {sq_rem[i][SW-1:0], sq_v[i][2*SW-1 -: 2]};
    assign trial  = {sq_root[i], 2'b01};
    assign take   = (rem_n >= trial);
    assign rem_d  = take ? rem_n - trial : rem_n;
    assign root_d = {sq_root[i][SW-2:0], take};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld[i+1] <= 1'b0;
      end else if (adv) begin
        sq_vld[i+1] <= sq_vld[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rem[i+1]  <= rem_d;
        sq_root[i+1] <= root_d;
        sq_v[i+1]    <= {sq_v[i][2*SW-3:0], 2'b00};
        sq_br[i+1]   <= sq_br[i];
        sq_na[i+1]   <= sq_na[i];
        sq_nb[i+1]   <= sq_nb[i];
        sq_nc[i+1]   <= sq_nc[i];
      end
    end
  end

  // ---- dividers, with root and branch carried alongside ----
  logic [QW-1:0]    qa, qb, qc;
  logic             ga, gb, gc;
  logic             dv_vld  [QW+1];
  r2q_pkg::branch_e dv_br   [QW+1];
  logic [SW-1:0]    dv_root [QW+1];

  r2q_div #(.FRAC_BITS(FRAC_BITS)) u_div_a (
    .clk_i (clk_i), .en_i (adv), .num_i (sq_na[SW]), .root_i (sq_root[SW]),
    .q_o   (qa),    .neg_o (ga)
  );
  r2q_div #(.FRAC_BITS(FRAC_BITS)) u_div_b (
    .clk_i (clk_i), .en_i (adv), .num_i (sq_nb[SW]), .root_i (sq_root[SW]),
    .q_o   (qb),    .neg_o (gb)
  );
  r2q_div #(.FRAC_BITS(FRAC_BITS)) u_div_c (
    .clk_i (clk_i), .en_i (adv), .num_i (sq_nc[SW]), .root_i (sq_root[SW]),
    .q_o   (qc),    .neg_o (gc)
  );

  assign dv_vld[0]  = sq_vld[SW];
  assign dv_br[0]   = sq_br[SW];
  assign dv_root[0] = sq_root[SW];

  for (genvar j = 0; j < QW; j++) begin : g_dly
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld[j+1] <= 1'b0;
      end else if (adv) begin
        dv_vld[j+1] <= dv_vld[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_br[j+1]   <= dv_br[j];
        dv_root[j+1] <= dv_root[j];
      end
    end
  end

  // ---- saturate, place the components, output register ----
  logic [SW:0]      p_full;
  logic [FW-1:0]    sp, sa, sb, sc;
  logic [FW-1:0]    x_d, y_d, z_d, w_d;
  logic [FW-1:0]    x_q, y_q, z_q, w_q;
  r2q_pkg::branch_e br_q;

  assign p_full = ({1'b0, dv_root[QW]} + 1'b1) >> 1;
  assign sp     = sat(XW'(p_full), 1'b0);
  assign sa     = sat(XW'(qa), ga);
  assign sb     = sat(XW'(qb), gb);
  assign sc     = sat(XW'(qc), gc);

  always_comb begin
    unique case (dv_br[QW])
      r2q_pkg::BR_TRACE: begin x_d = sa; y_d = sb; z_d = sc; w_d = sp; end
      r2q_pkg::BR_X:     begin x_d = sp; y_d = sa; z_d = sb; w_d = sc; end
      r2q_pkg::BR_Y:     begin x_d = sa; y_d = sp; z_d = sb; w_d = sc; end
      r2q_pkg::BR_Z:     begin x_d = sa; y_d = sb; z_d = sp; w_d = sc; end
      default:           begin x_d = sa; y_d = sb; z_d = sc; w_d = sp; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (adv) begin
      o_vld_q <= dv_vld[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q  <= x_d;
      y_q  <= y_d;
      z_q  <= z_d;
      w_q  <= w_d;
      br_q <= dv_br[QW];
    end
  end

  assign out_valid_o   = o_vld_q;
  assign quat_x_o      = x_q;
  assign quat_y_o      = y_q;
  assign quat_z_o      = z_q;
  assign quat_w_o      = w_q;
  assign branch_case_o = br_q;

endmodule

`default_nettype wire

>>> src/rotation_matrix_to_quaternion_top.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Rotation matrix to unit quaternion (Shepperd), fixed point, streaming.
// ----------------------------------------------------------------------------
//  channel | handshake                  | beat
//  in      | in_valid_i / in_ready_o    | r00_i .. r22_i, 18b signed
//  out     | out_valid_o / out_ready_i  | quat_x/y/z/w_o 18b signed, branch_case_o
//
//  One beat in and one beat out per cycle when the output is drained.
//  Pipeline: classifier register, queue, S root stages, 18 divider stages and
//  the output register, with S = (t_w + FRAC_BITS + 1) / 2.
//  During an output stall up to five more beats get in: four in the queue and
//  one in the classifier register; the arithmetic pipeline holds as a whole
//  while the output register is full.
//  Reset clears only the valid flags and the queue pointers and count.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion_top #(
  parameter int FRAC_BITS = r2q_pkg::FRAC_BITS_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire  signed [r2q_pkg::FIELD_W-1:0] r00_i,
  input  wire  signed [r2q_pkg::FIELD_W-1:0] r01_i,
  input  wire  signed [r2q_pkg::FIELD_W-1:0] r02_i,
  input  wire  signed [r2q_pkg::FIELD_W-1:0] r10_i,
  input  wire  signed [r2q_pkg::FIELD_W-1:0] r11_i,
  input  wire  signed [r2q_pkg::FIELD_W-1:0] r12_i,
  input  wire  signed [r2q_pkg::FIELD_W-1:0] r20_i,
  input  wire  signed [r2q_pkg::FIELD_W-1:0] r21_i,
  input  wire  signed [r2q_pkg::FIELD_W-1:0] r22_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic signed [r2q_pkg::FIELD_W-1:0] quat_x_o,
  output logic signed [r2q_pkg::FIELD_W-1:0] quat_y_o,
  output logic signed [r2q_pkg::FIELD_W-1:0] quat_z_o,
  output logic signed [r2q_pkg::FIELD_W-1:0] quat_w_o,
  output logic        [1:0]                  branch_case_o
);

  localparam int TW = r2q_pkg::t_w(FRAC_BITS);
  localparam int NW = r2q_pkg::NUM_W;
  localparam int QDW = 2 + TW + 3 * NW;

  logic                 f_valid, f_ready;
  r2q_pkg::branch_e     f_br;
  logic [TW-1:0]        f_t;
  logic signed [NW-1:0] f_na, f_nb, f_nc;

  logic                 b_valid, b_ready;
  logic [QDW-1:0]       q_in, q_out;
  r2q_pkg::branch_e     b_br;
  logic [TW-1:0]        b_t;
  logic signed [NW-1:0] b_na, b_nb, b_nc;

  r2q_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .r00_i      (r00_i),
    .r01_i      (r01_i),
    .r02_i      (r02_i),
    .r10_i      (r10_i),
    .r11_i      (r11_i),
    .r12_i      (r12_i),
    .r20_i      (r20_i),
    .r21_i      (r21_i),
    .r22_i      (r22_i),
    .f_valid_o  (f_valid),
    .f_ready_i  (f_ready),
    .f_br_o     (f_br),
    .f_t_o      (f_t),
    .f_na_o     (f_na),
    .f_nb_o     (f_nb),
    .f_nc_o     (f_nc)
  );

  assign q_in = {f_br, f_t, f_na, f_nb, f_nc};

  r2q_fifo #(.W(QDW), .DEPTH(r2q_pkg::FIFO_DEPTH)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (q_in),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (q_out)
  );

  assign b_br = r2q_pkg::branch_e'(q_out[QDW-1 -: 2]);
  assign b_t  = q_out[3*NW +: TW];
  assign b_na = q_out[2*NW +: NW];
  assign b_nb = q_out[NW +: NW];
  assign b_nc = q_out[0 +: NW];

  r2q_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .b_valid_i     (b_valid),
    .b_ready_o     (b_ready),
    .b_br_i        (b_br),
    .b_t_i         (b_t),
    .b_na_i        (b_na),
    .b_nb_i        (b_nb),
    .b_nc_i        (b_nc),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .quat_x_o      (quat_x_o),
    .quat_y_o      (quat_y_o),
    .quat_z_o      (quat_z_o),
    .quat_w_o      (quat_w_o),
    .branch_case_o (branch_case_o)
  );

endmodule

`default_nettype wire
